>>> hw/rtl/prl_pkg.sv
package prl_pkg;

  localparam int TABLE_ENTRIES = 64;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 48;
  localparam int COUNT_W = 16;
  localparam int WIN_W   = 32;
  localparam int DUR_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DUR = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RESET    = 32'd60000;
  localparam logic [COUNT_W-1:0] MAX_REQ_RESET   = 16'd100;
  localparam logic [DUR_W-1:0]   BLOCK_DUR_RESET = 32'd300000;

  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_BLOCKED = 2'd1;
  localparam logic [1:0] VERDICT_LIMIT   = 2'd2;
  localparam logic [1:0] VERDICT_FULL    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  now;
    logic [WIN_W-1:0]   window;
    logic [COUNT_W-1:0] max_req;
    logic [TIME_W-1:0]  block_end;
  } req_t;

  typedef struct packed {
    logic match;
    logic free;
  } slot_stat_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] count;
  } slot_res_t;

endpackage

>>> hw/rtl/prl_slot.sv
module prl_slot (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic                alloc,
  input  prl_pkg::req_t       req,
  output prl_pkg::slot_stat_t stat,
  output prl_pkg::slot_res_t  res
);

  logic                         valid;
  logic [prl_pkg::ADDR_W-1:0]   key;
  logic [prl_pkg::COUNT_W-1:0]  count;
  logic [prl_pkg::TIME_W-1:0]   win_start;
  logic                         blocked;
  logic [prl_pkg::TIME_W-1:0]   block_end;

  logic [prl_pkg::COUNT_W-1:0]  count_next;
  logic [prl_pkg::TIME_W-1:0]   win_start_next;
  logic                         blocked_next;
  logic [prl_pkg::TIME_W-1:0]   block_end_next;

  logic [prl_pkg::TIME_W-1:0]   age;
  logic [prl_pkg::COUNT_W-1:0]  cur_count;
  logic [prl_pkg::TIME_W-1:0]   cur_ws;
  logic                         cur_blk;
  logic [prl_pkg::TIME_W-1:0]   cur_be;
  logic [prl_pkg::TIME_W-1:0]   elapsed;
  logic                         expire;
  logic                         still_blocked;
  logic [prl_pkg::COUNT_W-1:0]  cnt1;
  logic [prl_pkg::TIME_W-1:0]   ws1;
  logic                         blk1;
  logic [prl_pkg::TIME_W-1:0]   be1;

  always_comb begin
    age = req.now - win_start;
    stat.match = valid && (key == req.addr);
    stat.free  = !valid ||
                 ((count == '0) &&
                  (age > {{(prl_pkg::TIME_W-prl_pkg::WIN_W-1){1'b0}}, req.window, 1'b0}));

    cur_count = alloc ? '0 : count;
    cur_ws    = alloc ? '0 : win_start;
    cur_blk   = alloc ? 1'b0 : blocked;
    cur_be    = alloc ? '0 : block_end;

    still_blocked = cur_blk && (req.now < cur_be);
    elapsed = req.now - cur_ws;
    expire  = elapsed >= {{(prl_pkg::TIME_W-prl_pkg::WIN_W){1'b0}}, req.window};

    cnt1 = expire ? '0 : cur_count;
    ws1  = expire ? req.now : cur_ws;
    blk1 = expire ? 1'b0 : cur_blk;
    be1  = expire ? '0 : cur_be;

    if (still_blocked) begin
      count_next        = cur_count;
      win_start_next    = cur_ws;
      blocked_next      = cur_blk;
      block_end_next    = cur_be;
      res.verdict       = prl_pkg::VERDICT_BLOCKED;
      res.count         = cur_count;
    end else if (cnt1 >= req.max_req) begin
      count_next        = cnt1;
      win_start_next    = ws1;
      blocked_next      = 1'b1;
      block_end_next    = req.block_end;
      res.verdict       = prl_pkg::VERDICT_LIMIT;
      res.count         = cnt1;
    end else begin
      count_next        = cnt1 + 1'b1;
      win_start_next    = ws1;
      blocked_next      = blk1;
      block_end_next    = be1;
      res.verdict       = prl_pkg::VERDICT_OK;
      res.count         = cnt1 + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key          <= req.addr;
      count        <= count_next;
      win_start    <= win_start_next;
      blocked      <= blocked_next;
      block_end    <= block_end_next;
    end
  end

endmodule

>>> hw/rtl/prl_pick.sv
module prl_pick (
  input  logic [prl_pkg::TABLE_ENTRIES-1:0] match,
  input  logic [prl_pkg::TABLE_ENTRIES-1:0] free,
  output logic [prl_pkg::TABLE_ENTRIES-1:0] sel,
  output logic                              alloc,
  output logic                              full
);

  logic [prl_pkg::TABLE_ENTRIES-1:0] cand;

  always_comb begin
    alloc = !(|match);
    cand  = alloc ? free : match;
    sel   = cand & (~cand + 1'b1);
    full  = alloc && !(|free);
  end

endmodule

>>> hw/rtl/per_client_rate_limiter.sv
// Pipeline: the accepting edge loads the input register; the result register is loaded
// along with the table update when that request advances, which waits while the output is stalled.
// Throughput: one transaction per cycle while out_ready does not stall the output; every slot
// is compared from its own flops, and only the selected slot is updated.
// Reset: configuration returns to its defaults and all slots become invalid at once.
module per_client_rate_limiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [prl_pkg::ADDR_W-1:0]     client_addr,
  input  logic [prl_pkg::TIME_W-1:0]     now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed,
  output logic [1:0]                     verdict_code,
  output logic [prl_pkg::COUNT_W-1:0]    count_after
);

  logic [prl_pkg::WIN_W-1:0]   window_ms;
  logic [prl_pkg::COUNT_W-1:0] max_requests;
  logic [prl_pkg::DUR_W-1:0]   block_duration_ms;

  logic                        s1_valid;
  logic [prl_pkg::ADDR_W-1:0]  s1_addr;
  logic [prl_pkg::TIME_W-1:0]  s1_now;

  logic                        advance;
  logic [prl_pkg::TIME_W:0]    end_sum;
  prl_pkg::req_t               req;

  logic [prl_pkg::TABLE_ENTRIES-1:0] match_vec;
  logic [prl_pkg::TABLE_ENTRIES-1:0] free_vec;
  logic [prl_pkg::TABLE_ENTRIES-1:0] sel;
  logic                              alloc;
  logic                              full;

  prl_pkg::slot_stat_t stat [prl_pkg::TABLE_ENTRIES];
  prl_pkg::slot_res_t  res  [prl_pkg::TABLE_ENTRIES];

  logic [1:0]                  verdict_next;
  logic [prl_pkg::COUNT_W-1:0] count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms         <= prl_pkg::WINDOW_RESET;
      max_requests      <= prl_pkg::MAX_REQ_RESET;
      block_duration_ms <= prl_pkg::BLOCK_DUR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prl_pkg::REG_WINDOW:    window_ms         <= cfg_data[prl_pkg::WIN_W-1:0];
        prl_pkg::REG_MAX_REQ:   max_requests      <= cfg_data[prl_pkg::COUNT_W-1:0];
        prl_pkg::REG_BLOCK_DUR: block_duration_ms <= cfg_data[prl_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_addr <= client_addr;
      s1_now  <= now_ms;
    end
  end

  always_comb begin
    end_sum = {1'b0, s1_now} +
              {{(prl_pkg::TIME_W+1-prl_pkg::DUR_W){1'b0}}, block_duration_ms};
    req.addr      = s1_addr;
    req.now       = s1_now;
    req.window    = window_ms;
    req.max_req   = max_requests;
    req.block_end = end_sum[prl_pkg::TIME_W] ? '1 : end_sum[prl_pkg::TIME_W-1:0];
  end

  for (genvar i = 0; i < prl_pkg::TABLE_ENTRIES; i++) begin : g_slot
    prl_slot u_slot (
      .clk   (clk),
      .rst   (rst),
      .wr    (advance && sel[i]),
      .alloc (alloc),
      .req   (req),
      .stat  (stat[i]),
      .res   (res[i])
    );
    assign match_vec[i] = stat[i].match;
    assign free_vec[i]  = stat[i].free;
  end

  prl_pick u_pick (
    .match (match_vec),
    .free  (free_vec),
    .sel   (sel),
    .alloc (alloc),
    .full  (full)
  );

  always_comb begin
    verdict_next = '0;
    count_next   = '0;
    for (int i = 0; i < prl_pkg::TABLE_ENTRIES; i++) begin
      verdict_next = verdict_next | (res[i].verdict & {2{sel[i]}});
      count_next   = count_next | (res[i].count & {prl_pkg::COUNT_W{sel[i]}});
    end
    if (full) begin
      verdict_next = prl_pkg::VERDICT_FULL;
      count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_code <= verdict_next;
      allowed      <= (verdict_next == prl_pkg::VERDICT_OK);
      count_after  <= count_next;
    end
  end

endmodule

>>> tb/per_client_rate_limiter_test.sv
module per_client_rate_limiter_test;
  import prl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_KEYS = 12;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
  } client_req_t;

  typedef struct packed {
    logic               allowed;
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] count;
  } admit_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     client_addr = '0;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  allowed;
  logic [1:0]            verdict_code;
  logic [COUNT_W-1:0]    count_after;

  // Predicted table and configuration
  logic               seen_valid     [TABLE_ENTRIES] = '{default: 1'b0};
  logic [ADDR_W-1:0]  seen_key       [TABLE_ENTRIES] = '{default: '0};
  logic [COUNT_W-1:0] seen_count     [TABLE_ENTRIES] = '{default: '0};
  logic [TIME_W-1:0]  seen_start     [TABLE_ENTRIES] = '{default: '0};
  logic               seen_blocked   [TABLE_ENTRIES] = '{default: 1'b0};
  logic [TIME_W-1:0]  seen_block_end [TABLE_ENTRIES] = '{default: '0};
  logic [WIN_W-1:0]   window_cfg = WINDOW_RESET;
  logic [COUNT_W-1:0] max_cfg    = MAX_REQ_RESET;
  logic [DUR_W-1:0]   block_cfg  = BLOCK_DUR_RESET;

  client_req_t       request_q[$];
  admit_t            verdict_q[$];
  client_req_t       next_req;
  admit_t            want;
  logic              in_fire = 1'b0;
  logic [ADDR_W-1:0] hot_keys[HOT_KEYS];
  logic [TIME_W-1:0] cur_now = '0;
  bit                quiet = 1'b0;
  int                send_gap = 0;
  int                stall_left = 0;
  int                cycles = 0;
  int                errors = 0;
  int                n_ok = 0;
  int                n_blocked = 0;
  int                n_limit = 0;
  int                n_full = 0;

  per_client_rate_limiter i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .client_addr  (client_addr),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .allowed      (allowed),
    .verdict_code (verdict_code),
    .count_after  (count_after)
  );

  always #5 clk = ~clk;

  function automatic admit_t admit_request(input logic [ADDR_W-1:0] addr,
                                           input logic [TIME_W-1:0] now);
    int                slot;
    int                i;
    logic [TIME_W-1:0] age;
    logic [TIME_W:0]   stop;
    slot = -1;
    for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
      if (seen_valid[i] && seen_key[i] == addr) slot = i;
    if (slot < 0) begin
      for (i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
        age = now - seen_start[i];
        if (!seen_valid[i] ||
            (seen_count[i] == '0 && {1'b0, age} > {16'd0, window_cfg, 1'b0}))
          slot = i;
      end
      if (slot < 0) return {1'b0, VERDICT_FULL, {COUNT_W{1'b0}}};
      seen_valid[slot]     = 1'b1;
      seen_key[slot]       = addr;
      seen_count[slot]     = '0;
      seen_start[slot]     = '0;
      seen_blocked[slot]   = 1'b0;
      seen_block_end[slot] = '0;
    end
    if (seen_blocked[slot] && now < seen_block_end[slot])
      return {1'b0, VERDICT_BLOCKED, seen_count[slot]};
    age = now - seen_start[slot];
    if (age >= {16'd0, window_cfg}) begin
      seen_count[slot]     = '0;
      seen_start[slot]     = now;
      seen_blocked[slot]   = 1'b0;
      seen_block_end[slot] = '0;
    end
    if (seen_count[slot] >= max_cfg) begin
      stop = {1'b0, now} + {17'd0, block_cfg};
      seen_blocked[slot]   = 1'b1;
      seen_block_end[slot] = stop[TIME_W] ? TIME_MAX : stop[TIME_W-1:0];
      return {1'b0, VERDICT_LIMIT, seen_count[slot]};
    end
    seen_count[slot] = seen_count[slot] + 1'b1;
    return {1'b1, VERDICT_OK, seen_count[slot]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    errors++;
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
  endtask

  // Cycle limit watchdog, input acceptance and result checking
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d results pending", verdict_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("transaction with nothing pending",
                          64'({allowed, verdict_code, count_after}), 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (allowed !== want.allowed)
            report_mismatch("allowed", 64'(allowed), 64'(want.allowed));
          if (verdict_code !== want.verdict)
            report_mismatch("verdict_code", 64'(verdict_code), 64'(want.verdict));
          if (count_after !== want.count)
            report_mismatch("count_after", 64'(count_after), 64'(want.count));
          case (want.verdict)
            VERDICT_OK:      n_ok++;
            VERDICT_BLOCKED: n_blocked++;
            VERDICT_LIMIT:   n_limit++;
            default:         n_full++;
          endcase
        end
      end
      if (in_valid && in_ready)
        verdict_q.insert(verdict_q.size(), admit_request(client_addr, now_ms));
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        next_req = request_q.pop_front();
        client_addr <= next_req.addr;
        now_ms      <= next_req.now;
        in_valid    <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_req(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
    request_q.insert(request_q.size(), client_req_t'({addr, now}));
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_WINDOW:    window_cfg = data[WIN_W-1:0];
      REG_MAX_REQ:   max_cfg    = data[COUNT_W-1:0];
      REG_BLOCK_DUR: block_cfg  = data[DUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [WIN_W-1:0] win, input logic [COUNT_W-1:0] maxr,
                           input logic [DUR_W-1:0] dur);
    wait_idle();
    write_reg(REG_WINDOW, win);
    write_reg(REG_MAX_REQ, {16'd0, maxr});
    write_reg(REG_BLOCK_DUR, dur);
  endtask

  task automatic random_items(input int n, input int fresh_pct);
    int                k;
    int                r;
    logic [63:0]       step;
    logic [63:0]       rnd;
    logic [ADDR_W-1:0] addr;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < fresh_pct) addr = $urandom;
      else if (r < fresh_pct + 45) addr = hot_keys[$urandom_range(0, 2)];
      else addr = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
      r = $urandom_range(0, 99);
      step = '0;
      if (r < 25) begin
        step = '0;
      end else if (r < 65) begin
        step = 64'($urandom_range(0, window_cfg / 8 + 1));
      end else if (r < 80) begin
        step = {32'd0, window_cfg} + ({32'd0, $urandom} % ({32'd0, window_cfg} + 64'd1));
      end else if (r < 90) begin
        step = ({32'd0, window_cfg} << 1) + 64'($urandom_range(1, 1000));
      end else if (r < 96) begin
        step = {32'd0, $urandom} % ({32'd0, block_cfg} + 64'd2);
      end else if (r < 98) begin
        rnd = {$urandom, $urandom};
        cur_now = rnd[TIME_W-1:0];
      end else begin
        cur_now = cur_now - 48'($urandom_range(1, 5000));
      end
      cur_now = cur_now + step[TIME_W-1:0];
      queue_req(addr, cur_now);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < HOT_KEYS; i++) hot_keys[i] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration, extreme addresses, new slot starting at time zero
    queue_req(32'h0000_0000, 48'd0);
    queue_req(32'hFFFF_FFFF, 48'd5);
    queue_req(32'h0000_0000, 48'd10);

    // Limit, still blocked, expired block inside the window, window rollover
    configure(32'd100, 16'd2, 32'd50);
    queue_req(32'h0A00_0001, 48'd1000);
    queue_req(32'h0A00_0001, 48'd1001);
    queue_req(32'h0A00_0001, 48'd1002);
    queue_req(32'h0A00_0001, 48'd1010);
    queue_req(32'h0A00_0001, 48'd1060);
    queue_req(32'h0A00_0001, 48'd1110);
    // Saturated block end near the top of time, then time going backwards
    queue_req(32'hC0A8_0101, TIME_MAX - 48'd30);
    queue_req(32'hC0A8_0101, TIME_MAX - 48'd30);
    queue_req(32'hC0A8_0101, TIME_MAX - 48'd30);
    queue_req(32'hC0A8_0101, TIME_MAX - 48'd1);
    queue_req(32'hC0A8_0101, 48'd5);
    queue_req(32'h0000_0303, 48'd3);

    // Zero window and zero request limit
    configure(32'd0, 16'd0, 32'd50);
    queue_req(32'h7F00_0001, 48'd10);
    queue_req(32'h7F00_0001, 48'd20);
    queue_req(32'h7F00_0001, 48'd70);

    cur_now = 48'd2000;
    configure(32'd1000, 16'd3, 32'd500);
    random_items(60, 5);
    wait_idle();
    random_items(60, 5);
    configure(32'd1, 16'd1, 32'd0);
    random_items(80, 5);
    configure(32'd0, 16'd2, 32'd100);
    random_items(60, 5);
    configure(32'd500, 16'd0, 32'd200);
    random_items(80, 10);
    configure(32'd2000, 16'd4, 32'hFFFF_FFFF);
    random_items(100, 5);
    configure(32'hFFFF_FFFF, 16'hFFFF, 32'd1000);
    random_items(60, 5);
    configure(32'd300, 16'd5, 32'd1000);
    random_items(160, 30);
    configure(32'd100, 16'd3, 32'd20);
    quiet = 1'b1;
    random_items(170, 10);

    wait_idle();
    repeat (6) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch("results never returned", 64'(verdict_q.size()), 64'd0);

    $display("Checked %0d requests over 11 register settings, with stalls on both sides",
             n_ok + n_blocked + n_limit + n_full);
    $display("Verdicts: %0d admitted, %0d still blocked, %0d over limit, %0d table full",
             n_ok, n_blocked, n_limit, n_full);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
